[design/gmps_pkg.sv]
package gmps_pkg;

   localparam int VID_W    = 20;
   localparam int BID_W    = 8;
   localparam int NCORNER  = 3;
   localparam int NBONE    = 4;
   localparam int NSLOT    = NCORNER * NBONE;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 11;

   localparam logic [CSR_IW-1:0] CSR_MAX_VERTICES     = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MAX_BONES        = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BONES_PER_VERTEX = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_BIG  = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;

   localparam logic [10:0] RST_MAX_VERTICES     = 11'd1024;
   localparam logic [6:0]  RST_MAX_BONES        = 7'd32;
   localparam logic [2:0]  RST_BONES_PER_VERTEX = 3'd4;

   typedef struct packed {
      logic [VID_W-1:0] vertex_id;
      logic [BID_W-1:0] bone_a;
      logic [BID_W-1:0] bone_b;
      logic [BID_W-1:0] bone_c;
      logic [BID_W-1:0] bone_d;
   } corner_type;

   typedef struct packed {
      corner_type [NCORNER-1:0] corner;
   } tri_type;

   typedef struct packed {
      logic [3:0] part_number;
      logic [9:0] local_first;
      logic [9:0] local_second;
      logic [9:0] local_third;
      logic       opened_part;
      logic [1:0] status;
   } rsp_type;

   function automatic logic [BID_W-1:0] corner_bone(corner_type c, logic [1:0] b);
      logic [BID_W-1:0] r;
      case (b)
         2'd0:    r = c.bone_a;
         2'd1:    r = c.bone_b;
         2'd2:    r = c.bone_c;
         default: r = c.bone_d;
      endcase
      return r;
   endfunction

endpackage

[design/gmps_queue.sv]
module gmps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gmps_pkg::tri_type push_data,
   output logic              full,
   output logic              pop_valid,
   output gmps_pkg::tri_type pop_data,
   input  logic              pop
);
   import gmps_pkg::*;

   tri_type    slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

endmodule

[design/gmps_front.sv]
module gmps_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gmps_pkg::corner_type req_data,
   output logic                 push,
   output gmps_pkg::tri_type    push_data,
   input  logic                 full
);
   import gmps_pkg::*;

   logic [1:0] pos_ff, pos_in;
   corner_type buf_ff [2];
   logic       take;

   // third corner waits while the queue is full
   assign req_stall = (pos_ff == 2'd2) && full;
   assign take      = req_valid && !req_stall;
   assign push      = take && (pos_ff == 2'd2);

   always_comb begin
      push_data.corner[0] = buf_ff[0];
      push_data.corner[1] = buf_ff[1];
      push_data.corner[2] = req_data;
      pos_in = pos_ff;
      if (take) begin
         pos_in = (pos_ff == 2'd2) ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pos_ff == 2'd0) buf_ff[0] <= req_data;
      if (take && pos_ff == 2'd1) buf_ff[1] <= req_data;
   end

endmodule

[design/gmps_back.sv]
module gmps_back #(
   parameter int MAX_PARTS       = 16,
   parameter int PART_VERTEX_CAP = 1024,
   parameter int PART_BONE_CAP   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gmps_pkg::CSR_IW-1:0]   csr_index,
   input  logic [gmps_pkg::CSR_DW-1:0]   csr_data,
   input  logic                          q_valid,
   input  gmps_pkg::tri_type             q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gmps_pkg::rsp_type             rsp_data
);
   import gmps_pkg::*;

   localparam int PW   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int OPW  = $clog2(MAX_PARTS + 1);
   localparam int LIW  = $clog2(PART_VERTEX_CAP);
   localparam int VCW  = $clog2(PART_VERTEX_CAP + 1);
   localparam int BIW  = (PART_BONE_CAP > 1) ? $clog2(PART_BONE_CAP) : 1;
   localparam int BCW  = $clog2(PART_BONE_CAP + 1);
   localparam int VAW  = $clog2(MAX_PARTS * PART_VERTEX_CAP);
   localparam int BAW  = (MAX_PARTS * PART_BONE_CAP > 1) ?
                         $clog2(MAX_PARTS * PART_BONE_CAP) : 1;
   localparam int SW   = (VCW > BCW) ? VCW : BCW;
   localparam int VSUM = ((VCW > 11) ? VCW : 11) + 2;
   localparam int BSUM = ((BCW > 7) ? BCW : 7) + 5;
   localparam int KW   = $clog2(NSLOT);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SCAN, S_EVAL, S_COMMIT, S_OUT
   } state_type;

   state_type        state_ff;
   logic [10:0]      max_v_ff;
   logic [6:0]       max_b_ff;
   logic [2:0]       bpv_ff;

   logic [VID_W-1:0] vmem [MAX_PARTS * PART_VERTEX_CAP];
   logic [BID_W-1:0] bmem [MAX_PARTS * PART_BONE_CAP];
   logic [VCW-1:0]   vcnt_ff [MAX_PARTS];
   logic [BCW-1:0]   bcnt_ff [MAX_PARTS];
   logic [OPW-1:0]   open_ff;

   tri_type          tri_ff;
   logic [OPW-1:0]   p_ff;
   logic [VCW-1:0]   vc_ff;
   logic [BCW-1:0]   bc_ff;
   logic             opening_ff;
   logic [SW-1:0]    iss_ff;
   logic             rdv_ff;
   logic [SW-1:0]    rdi_ff;
   logic [VID_W-1:0] vrd_ff;
   logic [BID_W-1:0] brd_ff;
   logic [2:0]       vfound_ff;
   logic [LIW-1:0]   vloc_ff [NCORNER];
   logic [NSLOT-1:0] bfound_ff;

   logic [2:0]       vnew_ff;
   logic [NSLOT-1:0] bnew_ff;
   logic [LIW-1:0]   loc_ff [NCORNER];
   logic [BIW-1:0]   bwp_ff;
   logic [KW-1:0]    k_ff;
   logic [VCW-1:0]   nvc_ff;
   logic [BCW-1:0]   nbc_ff;
   logic             res_open_ff;
   logic [1:0]       res_status_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [PW-1:0]    pidx;
   logic [2:0]       bpv_eff;
   logic [BID_W-1:0] slot_bid [NSLOT];
   logic [NSLOT-1:0] slot_act;
   logic [2:0]       vnew_c;
   logic [NSLOT-1:0] bnew_c;
   logic [LIW-1:0]   loc_c [NCORNER];
   logic [1:0]       nnv, nnv_e;
   logic [3:0]       nnb, nnb_e;
   logic [VSUM-1:0]  vlim;
   logic [BSUM-1:0]  blim;
   logic             fit, fit_e;
   logic [SW-1:0]    smax;
   logic [SW-1:0]    vi, bi;
   logic [VAW-1:0]   vrd_addr, vwr_addr;
   logic [BAW-1:0]   brd_addr, bwr_addr;
   logic             vwe, bwe;
   logic             rd_issue;

   assign pidx      = p_ff[PW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      bpv_eff = (bpv_ff > 3'd4) ? 3'd4 : bpv_ff;
      for (int k = 0; k < NSLOT; k++) begin
         slot_bid[k] = corner_bone(tri_ff.corner[k / NBONE], 2'(k % NBONE));
         slot_act[k] = (3'(k % NBONE) < bpv_eff);
      end
   end

   // dedup of the triangle against the scan result and within itself
   always_comb begin
      logic dup;
      nnv = 2'd0;
      nnv_e = 2'd0;
      for (int c = 0; c < NCORNER; c++) begin
         dup = 1'b0;
         loc_c[c] = vloc_ff[c];
         for (int j = 0; j < c; j++) begin
            if (!dup && tri_ff.corner[j].vertex_id == tri_ff.corner[c].vertex_id) begin
               dup = 1'b1;
               if (!vfound_ff[c]) loc_c[c] = loc_c[j];
            end
         end
         vnew_c[c] = !vfound_ff[c] && !dup;
         if (vnew_c[c]) begin
            loc_c[c] = LIW'(vc_ff) + LIW'(nnv);
            nnv = nnv + 2'd1;
         end
         if (!dup) nnv_e = nnv_e + 2'd1;
      end
      nnb = 4'd0;
      nnb_e = 4'd0;
      for (int k = 0; k < NSLOT; k++) begin
         dup = 1'b0;
         for (int j = 0; j < k; j++) begin
            if (slot_act[j] && slot_bid[j] == slot_bid[k]) dup = 1'b1;
         end
         bnew_c[k] = slot_act[k] && !bfound_ff[k] && !dup;
         if (bnew_c[k]) nnb = nnb + 4'd1;
         if (slot_act[k] && !dup) nnb_e = nnb_e + 4'd1;
      end
      vlim = (VSUM'(max_v_ff) < VSUM'(PART_VERTEX_CAP)) ?
             VSUM'(max_v_ff) : VSUM'(PART_VERTEX_CAP);
      blim = (BSUM'(max_b_ff) < BSUM'(PART_BONE_CAP)) ?
             BSUM'(max_b_ff) : BSUM'(PART_BONE_CAP);
      fit   = (VSUM'(vc_ff) + VSUM'(nnv) <= vlim) && (BSUM'(bc_ff) + BSUM'(nnb) <= blim);
      fit_e = (VSUM'(nnv_e) <= vlim) && (BSUM'(nnb_e) <= blim);
   end

   always_comb begin
      smax     = (SW'(vc_ff) > SW'(bc_ff)) ? SW'(vc_ff) : SW'(bc_ff);
      rd_issue = (state_ff == S_SCAN) && (iss_ff < smax);
      vi       = (iss_ff < SW'(vc_ff)) ? iss_ff : '0;
      bi       = (iss_ff < SW'(bc_ff)) ? iss_ff : '0;
      vrd_addr = VAW'(32'(pidx) * PART_VERTEX_CAP) + VAW'(vi);
      brd_addr = BAW'(32'(pidx) * PART_BONE_CAP) + BAW'(bi);
      vwe      = (state_ff == S_COMMIT) && (32'(k_ff) < NCORNER) &&
                 vnew_ff[k_ff[1:0]];
      bwe      = (state_ff == S_COMMIT) && bnew_ff[k_ff];
      vwr_addr = VAW'(32'(pidx) * PART_VERTEX_CAP) + VAW'(loc_ff[k_ff[1:0]]);
      bwr_addr = BAW'(32'(pidx) * PART_BONE_CAP) + BAW'(bwp_ff);
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         vrd_ff <= vmem[vrd_addr];
         brd_ff <= bmem[brd_addr];
      end
      if (vwe) vmem[vwr_addr] <= tri_ff.corner[k_ff[1:0]].vertex_id;
      if (bwe) bmem[bwr_addr] <= slot_bid[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_v_ff     <= RST_MAX_VERTICES;
         max_b_ff     <= RST_MAX_BONES;
         bpv_ff       <= RST_BONES_PER_VERTEX;
         open_ff      <= OPW'(1);
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         for (int i = 0; i < MAX_PARTS; i++) begin
            vcnt_ff[i] <= '0;
            bcnt_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_VERTICES:     max_v_ff <= csr_data;
               CSR_MAX_BONES:        max_b_ff <= csr_data[6:0];
               CSR_BONES_PER_VERTEX: bpv_ff   <= csr_data[2:0];
               default: ;
            endcase
         end
         // the output state reloads the register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         rdv_ff <= rd_issue;
         if (rd_issue) begin
            rdi_ff <= iss_ff;
            iss_ff <= iss_ff + SW'(1);
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  tri_ff   <= q_data;
                  p_ff     <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               vfound_ff <= '0;
               bfound_ff <= '0;
               iss_ff    <= '0;
               if (p_ff < open_ff) begin
                  vc_ff      <= vcnt_ff[pidx];
                  bc_ff      <= bcnt_ff[pidx];
                  opening_ff <= 1'b0;
                  state_ff   <= S_SCAN;
               end else if (!fit_e) begin
                  res_status_ff <= ST_TOO_BIG;
                  state_ff      <= S_OUT;
               end else if (32'(open_ff) >= MAX_PARTS) begin
                  res_status_ff <= ST_EXHAUSTED;
                  state_ff      <= S_OUT;
               end else begin
                  vc_ff      <= '0;
                  bc_ff      <= '0;
                  opening_ff <= 1'b1;
                  state_ff   <= S_EVAL;
               end
            end
            S_SCAN: begin
               if (rdv_ff) begin
                  for (int c = 0; c < NCORNER; c++) begin
                     if (rdi_ff < SW'(vc_ff) && !vfound_ff[c] &&
                         vrd_ff == tri_ff.corner[c].vertex_id) begin
                        vfound_ff[c] <= 1'b1;
                        vloc_ff[c]   <= LIW'(rdi_ff);
                     end
                  end
                  for (int k = 0; k < NSLOT; k++) begin
                     if (rdi_ff < SW'(bc_ff) && brd_ff == slot_bid[k]) bfound_ff[k] <= 1'b1;
                  end
               end
               if (!rd_issue && !rdv_ff) state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (fit) begin
                  vnew_ff  <= vnew_c;
                  bnew_ff  <= bnew_c;
                  for (int c = 0; c < NCORNER; c++) loc_ff[c] <= loc_c[c];
                  bwp_ff   <= BIW'(bc_ff);
                  k_ff     <= '0;
                  nvc_ff   <= vc_ff + VCW'(nnv);
                  nbc_ff   <= bc_ff + BCW'(nnb);
                  state_ff <= S_COMMIT;
               end else begin
                  p_ff     <= p_ff + OPW'(1);
                  state_ff <= S_LOAD;
               end
            end
            S_COMMIT: begin
               if (bwe) bwp_ff <= bwp_ff + BIW'(1);
               k_ff <= k_ff + KW'(1);
               if (32'(k_ff) == NSLOT - 1) begin
                  vcnt_ff[pidx] <= nvc_ff;
                  bcnt_ff[pidx] <= nbc_ff;
                  if (opening_ff) open_ff <= open_ff + OPW'(1);
                  res_open_ff   <= opening_ff;
                  res_status_ff <= ST_OK;
                  state_ff      <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.status <= res_status_ff;
                  if (res_status_ff == ST_OK) begin
                     rsp_ff.part_number  <= 4'(p_ff);
                     rsp_ff.local_first  <= 10'(loc_ff[0]);
                     rsp_ff.local_second <= 10'(loc_ff[1]);
                     rsp_ff.local_third  <= 10'(loc_ff[2]);
                     rsp_ff.opened_part  <= res_open_ff;
                  end else begin
                     rsp_ff.part_number  <= '0;
                     rsp_ff.local_first  <= '0;
                     rsp_ff.local_second <= '0;
                     rsp_ff.local_third  <= '0;
                     rsp_ff.opened_part  <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[design/greedy_mesh_part_splitter.sv]
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_data   (one triangle corner)
// rsp       out        rsp_valid/rsp_stall   rsp_data   (one result per triangle)
// csr       in         csr_we                csr_index, csr_data
//
// first two corners of a triangle are taken one per cycle; the third is
// queued, popped and then tried against each open part: a load step, then
// a scan of the part's vertex and bone lists on its memory read port and
// an evaluate step; a new part skips the scan. a fitting part then goes
// through the commit and output steps. reset is synchronous and restores
// one open empty part. req stalls only when the two-entry triangle queue
// is full.
module greedy_mesh_part_splitter #(
   parameter int MAX_PARTS       = 16,
   parameter int PART_VERTEX_CAP = 1024,
   parameter int PART_BONE_CAP   = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  gmps_pkg::corner_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output gmps_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [gmps_pkg::CSR_IW-1:0] csr_index,
   input  logic [gmps_pkg::CSR_DW-1:0] csr_data
);
   import gmps_pkg::*;

   logic    push, full, q_valid, q_pop;
   tri_type push_data, q_data;

   gmps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   gmps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .pop       (q_pop)
   );

   gmps_back #(
      .MAX_PARTS       (MAX_PARTS),
      .PART_VERTEX_CAP (PART_VERTEX_CAP),
      .PART_BONE_CAP   (PART_BONE_CAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/tb_greedy_mesh_part_splitter.sv]
`timescale 1ns / 100ps

module tb_greedy_mesh_part_splitter;
   import gmps_pkg::*;

   localparam int NPARTS = 16;
   localparam int VCAP = 1024;
   localparam int BCAP = 64;
   localparam int CYCLE_LIMIT = 20000000;
   localparam logic [CSR_IW-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      corner_type c;
      bit         typed;
      rsp_type    r;
   } dir_row_type;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   corner_type          req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   rsp_type             rsp_data;
   logic                csr_we = 0;
   logic [CSR_IW-1:0]   csr_index = '0;
   logic [CSR_DW-1:0]   csr_data = '0;

   // predictor state
   logic [VID_W-1:0] vert_tab [NPARTS][VCAP];
   logic [BID_W-1:0] bone_tab [NPARTS][BCAP];
   int               vert_cnt [NPARTS];
   int               bone_cnt [NPARTS];
   int               parts_open;
   corner_type       corner_buf [3];
   int               corner_pos;
   int               cfg_vmax, cfg_bmax, cfg_bpv;

   rsp_type     placements_due [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          corners_sent = 0;
   int          status_seen [4];
   int          cycles = 0;
   bit          idle_on = 1;
   int          stall_left = 0;
   dir_row_type dir_rows [15];

   greedy_mesh_part_splitter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // offer the gathered triangle to part p, or to an empty part
   function automatic bit fits_part(int p, bit empty, bit commit, output int loc[3]);
      int vc, bc, nnv, nnb, bpv, vlim, blim;
      logic [VID_W-1:0] nv [3];
      logic [BID_W-1:0] nb [12];
      logic [3:0][BID_W-1:0] bl;
      logic [BID_W-1:0] bid;
      bit hit;
      vc = empty ? 0 : vert_cnt[p];
      bc = empty ? 0 : bone_cnt[p];
      nnv = 0;
      nnb = 0;
      bpv = cfg_bpv > 4 ? 4 : cfg_bpv;
      vlim = cfg_vmax < VCAP ? cfg_vmax : VCAP;
      blim = cfg_bmax < BCAP ? cfg_bmax : BCAP;
      for (int c = 0; c < 3; c++) begin
         hit = 0;
         for (int i = 0; i < vc && !hit; i++) begin
            if (vert_tab[p][i] == corner_buf[c].vertex_id) begin
               loc[c] = i;
               hit = 1;
            end
         end
         for (int i = 0; i < nnv && !hit; i++) begin
            if (nv[i] == corner_buf[c].vertex_id) begin
               loc[c] = vc + i;
               hit = 1;
            end
         end
         if (!hit) begin
            loc[c] = vc + nnv;
            nv[nnv] = corner_buf[c].vertex_id;
            nnv++;
         end
         bl = {corner_buf[c].bone_a, corner_buf[c].bone_b,
               corner_buf[c].bone_c, corner_buf[c].bone_d};
         for (int b = 0; b < bpv; b++) begin
            bid = bl[3-b];
            hit = 0;
            for (int i = 0; i < bc && !hit; i++)
               if (bone_tab[p][i] == bid) hit = 1;
            for (int i = 0; i < nnb && !hit; i++)
               if (nb[i] == bid) hit = 1;
            if (!hit) begin
               nb[nnb] = bid;
               nnb++;
            end
         end
      end
      if (vc + nnv > vlim || bc + nnb > blim) return 0;
      if (commit) begin
         for (int i = 0; i < nnv; i++) vert_tab[p][vc+i] = nv[i];
         for (int i = 0; i < nnb; i++) bone_tab[p][bc+i] = nb[i];
         vert_cnt[p] = vc + nnv;
         bone_cnt[p] = bc + nnb;
      end
      return 1;
   endfunction

   // first-fit placement of a completed triangle
   function automatic rsp_type place_triangle();
      int loc [3];
      bit placed;
      rsp_type r;
      r = '0;
      placed = 0;
      for (int p = 0; p < parts_open && !placed; p++) begin
         if (fits_part(p, 0, 1, loc)) begin
            r.part_number = 4'(p);
            placed = 1;
         end
      end
      if (!placed) begin
         if (!fits_part(0, 1, 0, loc)) begin
            r.status = ST_TOO_BIG;
         end else if (parts_open >= NPARTS) begin
            r.status = ST_EXHAUSTED;
         end else begin
            vert_cnt[parts_open] = 0;
            bone_cnt[parts_open] = 0;
            void'(fits_part(parts_open, 0, 1, loc));
            r.part_number = 4'(parts_open);
            r.opened_part = 1'b1;
            parts_open++;
            placed = 1;
         end
      end
      if (placed) begin
         r.local_first = 10'(loc[0]);
         r.local_second = 10'(loc[1]);
         r.local_third = 10'(loc[2]);
      end
      return r;
   endfunction

   // send one corner; returns once it is taken
   task automatic send_corner(corner_type c, bit typed, rsp_type typed_r);
      rsp_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= c;
      do @(posedge clock); while (req_stall);
      corners_sent++;
      corner_buf[corner_pos] = c;
      if (corner_pos < 2) begin
         corner_pos++;
      end else begin
         corner_pos = 0;
         r = place_triangle();
         placements_due = {placements_due, (typed ? typed_r : r)};
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_regs(int mv, int mb, int bpv);
      csr_we <= 1;
      csr_index <= CSR_MAX_VERTICES;
      csr_data <= CSR_DW'(mv);
      @(posedge clock);
      csr_index <= CSR_MAX_BONES;
      csr_data <= CSR_DW'(mb);
      @(posedge clock);
      csr_index <= CSR_BONES_PER_VERTEX;
      csr_data <= CSR_DW'(bpv);
      @(posedge clock);
      // ignored index
      csr_index <= CSR_UNUSED_INDEX;
      csr_data <= '1;
      @(posedge clock);
      csr_we <= 0;
      cfg_vmax = mv & 11'h7ff;
      cfg_bmax = mb & 7'h7f;
      cfg_bpv = bpv & 3'h7;
   endtask

   task automatic random_triangles(int count, int vpool, int bpool);
      corner_type c;
      for (int n = 0; n < count * 3; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            c = corner_type'(52'({$urandom, $urandom}));
         end else begin
            c.vertex_id = VID_W'($urandom_range(0, vpool));
            c.bone_a = BID_W'($urandom_range(0, bpool));
            c.bone_b = BID_W'($urandom_range(0, bpool));
            c.bone_c = BID_W'($urandom_range(0, bpool));
            c.bone_d = BID_W'($urandom_range(0, bpool));
         end
         send_corner(c, 0, '0);
      end
   endtask

   // result side stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_seen[rsp_data.status]++;
         if (placements_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: part %0d locals %0d %0d %0d opened %0d status %0d",
                        rsp_data.part_number, rsp_data.local_first, rsp_data.local_second,
                        rsp_data.local_third, rsp_data.opened_part, rsp_data.status);
         end else begin
            want = placements_due.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at result %0d: exp part %0d loc %0d %0d %0d op %0d st %0d, got part %0d loc %0d %0d %0d op %0d st %0d",
                           results_seen, want.part_number, want.local_first,
                           want.local_second, want.local_third, want.opened_part,
                           want.status, rsp_data.part_number, rsp_data.local_first,
                           rsp_data.local_second, rsp_data.local_third,
                           rsp_data.opened_part, rsp_data.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  placements_due.size());
         $display("** greedy_mesh_part_splitter: FAILED **");
         $finish;
      end
   end

   initial begin
      cfg_vmax = int'(RST_MAX_VERTICES);
      cfg_bmax = int'(RST_MAX_BONES);
      cfg_bpv = int'(RST_BONES_PER_VERTEX);
      parts_open = 1;
      corner_pos = 0;
      foreach (vert_cnt[i]) begin
         vert_cnt[i] = 0;
         bone_cnt[i] = 0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;

      dir_rows = '{
         // three new vertices in part 0
         '{corner_type'{20'd0, 8'd1, 8'd2, 8'd3, 8'd4}, 0, '0},
         '{corner_type'{20'd1, 8'd1, 8'd2, 8'd3, 8'd4}, 0, '0},
         '{corner_type'{20'd2, 8'd5, 8'd6, 8'd7, 8'd8}, 1,
           rsp_type'{4'd0, 10'd0, 10'd1, 10'd2, 1'b0, ST_OK}},
         // top vertex id and bone ids, same corner three times
         '{corner_type'{20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 0, '0},
         '{corner_type'{20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 0, '0},
         '{corner_type'{20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 1,
           rsp_type'{4'd0, 10'd3, 10'd3, 10'd3, 1'b0, ST_OK}},
         // reuse of known vertices
         '{corner_type'{20'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 0, '0},
         '{corner_type'{20'hfffff, 8'd0, 8'd0, 8'd0, 8'd0}, 0, '0},
         '{corner_type'{20'd7, 8'd0, 8'd0, 8'd0, 8'd0}, 1,
           rsp_type'{4'd0, 10'd0, 10'd3, 10'd4, 1'b0, ST_OK}},
         // twelve new bones, still fits the bone limit
         '{corner_type'{20'd8, 8'd100, 8'd101, 8'd102, 8'd103}, 0, '0},
         '{corner_type'{20'd9, 8'd104, 8'd105, 8'd106, 8'd107}, 0, '0},
         '{corner_type'{20'd10, 8'd108, 8'd109, 8'd110, 8'd111}, 1,
           rsp_type'{4'd0, 10'd5, 10'd6, 10'd7, 1'b0, ST_OK}},
         // bone limit overflows, a second part opens
         '{corner_type'{20'd11, 8'd120, 8'd121, 8'd122, 8'd123}, 0, '0},
         '{corner_type'{20'd12, 8'd124, 8'd125, 8'd126, 8'd127}, 0, '0},
         '{corner_type'{20'd13, 8'd128, 8'd129, 8'd130, 8'd131}, 1,
           rsp_type'{4'd1, 10'd0, 10'd1, 10'd2, 1'b1, ST_OK}}
      };

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) send_corner(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      random_triangles(140, 63, 23);
      drain();

      // limits above storage, bone count saturates
      write_regs(2047, 127, 7);
      random_triangles(140, 127, 47);
      drain();

      // tight limits: too big and parts exhausted
      write_regs(3, 1, 1);
      random_triangles(60, 15, 3);
      drain();

      // zero limits, bones ignored
      write_regs(0, 0, 0);
      random_triangles(20, 15, 3);
      drain();

      write_regs(6, 64, 0);
      random_triangles(60, 31, 7);
      drain();

      write_regs(1, 5, 2);
      random_triangles(60, 7, 7);
      drain();

      // defaults again, no idling on either side
      write_regs(1024, 32, 4);
      idle_on = 0;
      random_triangles(130, 63, 15);
      drain();

      $display("sent %0d corners, checked %0d results over seven limit settings",
               corners_sent, results_seen);
      $display("status counts: ok %0d, too big %0d, exhausted %0d; %0d parts open",
               status_seen[ST_OK], status_seen[ST_TOO_BIG], status_seen[ST_EXHAUSTED],
               parts_open);
      if (mismatches == 0 && placements_due.size() == 0) begin
         $display("** greedy_mesh_part_splitter: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** greedy_mesh_part_splitter: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
design/gmps_pkg.sv
design/gmps_queue.sv
design/gmps_front.sv
design/gmps_back.sv
design/greedy_mesh_part_splitter.sv
dv/tb_greedy_mesh_part_splitter.sv
